// File: design/dht_pkg.sv
package dht_pkg;

    localparam int KEY_WIDTH  = 30;
    localparam int STATUS_W   = 3;
    localparam int CMP_W      = 6;
    localparam int STEP_PRIME = 13;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic                 mode;
        logic [KEY_WIDTH-1:0] key;
    } dht_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CMP_W-1:0]    comparisons;
    } dht_resp_t;

    typedef struct packed {
        logic [1:0]           mark;
        logic [KEY_WIDTH-1:0] key;
    } dht_slot_t;

endpackage

// File: design/dht_slot_mem.sv
module dht_slot_mem #(
    parameter int TABLE_SIZE = 37,
    localparam int AW = $clog2(TABLE_SIZE)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  dht_pkg::dht_slot_t wdata,
    input  logic [AW-1:0]     raddr,
    output dht_pkg::dht_slot_t rdata
);
    import dht_pkg::*;

    dht_slot_t mem_reg [TABLE_SIZE];
    dht_slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/dht_addr_gen.sv
module dht_addr_gen #(
    parameter int TABLE_SIZE = 37,
    localparam int AW = $clog2(TABLE_SIZE)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [dht_pkg::KEY_WIDTH-1:0] key,
    input  logic                          adv,
    output logic                          ready,
    output logic [AW-1:0]                 addr
);
    import dht_pkg::*;

    // ceil(2^sh / d): exact quotient for any KEY_WIDTH-bit dividend when sh = KEY_WIDTH + clog2(d)
    function automatic longint unsigned recip(input int sh, input int d);
        return ((64'd1 << sh) + 64'(d) - 64'd1) / 64'(d);
    endfunction

    localparam int TW  = $clog2(TABLE_SIZE + 1);
    localparam int SW  = (TW > 4) ? TW : 4;
    localparam int PW  = 2 * KEY_WIDTH + 1;
    localparam int TSH = KEY_WIDTH + $clog2(TABLE_SIZE);
    localparam int PSH = KEY_WIDTH + $clog2(STEP_PRIME);
    localparam logic [KEY_WIDTH:0] T_RECIP = (KEY_WIDTH+1)'(recip(TSH, TABLE_SIZE));
    localparam logic [KEY_WIDTH:0] P_RECIP = (KEY_WIDTH+1)'(recip(PSH, STEP_PRIME));

    typedef enum logic [4:0] {
        AG_IDLE  = 5'b00001,
        AG_MUL   = 5'b00010,
        AG_HASH  = 5'b00100,
        AG_STEP  = 5'b01000,
        AG_READY = 5'b10000
    } ag_state_t;

    ag_state_t            st_reg, st_next;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] qt_reg;
    logic [KEY_WIDTH-1:0] qp_reg;
    logic [AW-1:0]        rt_reg;
    logic [SW-1:0]        step_reg;
    logic [AW-1:0]        addr_reg;

    logic [PW-1:0]        qt_prod;
    logic [PW-1:0]        qp_prod;
    logic [KEY_WIDTH-1:0] rt_full;
    logic [KEY_WIDTH-1:0] rp_full;
    logic [AW:0]          sum;
    logic [AW:0]          sum_red;

    assign qt_prod = {{(KEY_WIDTH+1){1'b0}}, key_reg} * {{KEY_WIDTH{1'b0}}, T_RECIP};
    assign qp_prod = {{(KEY_WIDTH+1){1'b0}}, key_reg} * {{KEY_WIDTH{1'b0}}, P_RECIP};
    assign rt_full = key_reg - qt_reg * KEY_WIDTH'(TABLE_SIZE);
    assign rp_full = key_reg - qp_reg * KEY_WIDTH'(STEP_PRIME);
    assign sum     = {1'b0, addr_reg} + {1'b0, step_reg[AW-1:0]};
    assign sum_red = (sum >= (AW+1)'(TABLE_SIZE)) ? sum - (AW+1)'(TABLE_SIZE) : sum;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            AG_IDLE:  ;
            AG_MUL:   st_next = AG_HASH;
            AG_HASH:  st_next = AG_STEP;
            AG_STEP:
            begin
                if (step_reg < SW'(TABLE_SIZE))
                begin
                    st_next = AG_READY;
                end
            end
            AG_READY: ;
            default:  st_next = AG_IDLE;
        endcase
        if (load)
        begin
            st_next = AG_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= AG_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg <= key;
        end
        else if (st_reg == AG_MUL)
        begin
            qt_reg <= KEY_WIDTH'(qt_prod >> TSH);
            qp_reg <= KEY_WIDTH'(qp_prod >> PSH);
        end
        else if (st_reg == AG_HASH)
        begin
            rt_reg   <= rt_full[AW-1:0];
            step_reg <= SW'(rp_full[3:0]) + SW'(1);
        end
        else if (st_reg == AG_STEP)
        begin
            if (step_reg >= SW'(TABLE_SIZE))
            begin
                step_reg <= step_reg - SW'(TABLE_SIZE);
            end
            addr_reg <= rt_reg;
        end
        else if (st_reg == AG_READY && adv)
        begin
            addr_reg <= sum_red[AW-1:0];
        end
    end

    assign ready = (st_reg == AG_READY);
    assign addr  = addr_reg;

endmodule

// File: design/double_hash_table_insert_delete_unit.sv
// channel   direction  handshake              payload
// request   in         start & !busy          req   (mode, key)
// result    out        done, one cycle        resp  (status, comparisons)
//
// After reset the slot marks are cleared, one slot a cycle, and busy stays high until
// every slot is cleared. After the accepting edge the address generator finds the home
// slot and step by reciprocal multiplication in its multiply, hash and step states; then
// one slot is read per cycle and judged in the cycle after (TABLE_SIZE below 14 may
// repeat the step reduction). busy is high from acceptance until the cycle done is
// raised, so a new request waits for the last result; the result is never held off.
module double_hash_table_insert_delete_unit #(
    parameter int TABLE_SIZE = 37
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dht_pkg::dht_req_t  req,
    output logic              done,
    output dht_pkg::dht_resp_t resp
);
    import dht_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int TW = $clog2(TABLE_SIZE + 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_PROBE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_reg;
    logic                 mode_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [TW-1:0]        issue_cnt_reg;
    logic                 rd_valid_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic                 rd_last_reg;
    logic                 have_hole_reg;
    logic [AW-1:0]        hole_reg;
    logic [CMP_W-1:0]     n_reg;
    logic                 done_reg;
    dht_resp_t            resp_reg;

    logic                 accept;
    logic                 ag_ready;
    logic [AW-1:0]        ag_addr;
    logic                 issue;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    dht_slot_t            mem_wdata;
    dht_slot_t            mem_rdata;
    logic                 used;
    logic                 match;
    logic                 empty;
    logic                 other;
    logic [CMP_W-1:0]     n_inc;
    logic                 term;
    dht_resp_t            resp_next;

    assign accept = start && !busy;
    assign issue  = (state_reg == S_PROBE) && (issue_cnt_reg != TW'(TABLE_SIZE));

    dht_addr_gen #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_addr_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .key   (req.key),
        .adv   (issue),
        .ready (ag_ready),
        .addr  (ag_addr)
    );

    dht_slot_mem #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (ag_addr),
        .rdata (mem_rdata)
    );

    assign used  = (mem_rdata.mark == MARK_USED);
    assign empty = (mem_rdata.mark == MARK_EMPTY);
    assign other = !used && !empty;
    assign match = used && (mem_rdata.key == key_reg);
    assign n_inc = n_reg + CMP_W'(used);

    // clear writes after reset, and probe evaluation, one returned slot a cycle
    always_comb
    begin
        term      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = rd_addr_reg;
        mem_wdata = '{mark: MARK_USED, key: key_reg};
        resp_next = resp_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '{mark: MARK_EMPTY, key: '0};
        end
        else if (state_reg == S_PROBE && rd_valid_reg)
        begin
            if (mode_reg == MODE_INSERT)
            begin
                if (match)
                begin
                    term      = 1'b1;
                    resp_next = '{status: STAT_DUPLICATE, comparisons: n_inc};
                end
                else if (empty)
                begin
                    term      = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = have_hole_reg ? hole_reg : rd_addr_reg;
                    resp_next = '{status: STAT_INSERTED, comparisons: n_reg};
                end
                else if (rd_last_reg)
                begin
                    term = 1'b1;
                    if (have_hole_reg || other)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = have_hole_reg ? hole_reg : rd_addr_reg;
                        resp_next = '{status: STAT_INSERTED, comparisons: n_inc};
                    end
                    else
                    begin
                        resp_next = '{status: STAT_FULL, comparisons: CMP_W'(TABLE_SIZE)};
                    end
                end
            end
            else
            begin
                if (match)
                begin
                    term      = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = '{mark: MARK_DELETED, key: key_reg};
                    resp_next = '{status: STAT_DELETED, comparisons: n_inc};
                end
                else if (empty)
                begin
                    term      = 1'b1;
                    resp_next = '{status: STAT_NOT_FOUND, comparisons: n_reg};
                end
                else if (rd_last_reg)
                begin
                    term      = 1'b1;
                    resp_next = '{status: STAT_NOT_FOUND, comparisons: n_inc};
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (ag_ready)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (term)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= term;
            rd_valid_reg <= issue;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            key_reg  <= req.key;
        end
        if (state_reg == S_HASH)
        begin
            issue_cnt_reg <= '0;
            have_hole_reg <= 1'b0;
            n_reg         <= '0;
        end
        else if (state_reg == S_PROBE)
        begin
            if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                rd_addr_reg   <= ag_addr;
                rd_last_reg   <= (issue_cnt_reg == TW'(TABLE_SIZE - 1));
            end
            if (rd_valid_reg)
            begin
                n_reg <= n_inc;
                if (mode_reg == MODE_INSERT && other && !have_hole_reg)
                begin
                    have_hole_reg <= 1'b1;
                    hole_reg      <= rd_addr_reg;
                end
            end
        end
        if (term)
        begin
            resp_reg <= resp_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign resp = resp_reg;

    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_HASH)
        else $error("request accepted but hashing not started");

    a_done_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_PROBE))
        else $error("result without probing");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_PROBE))
        else $error("table written outside clear or probe");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && resp.status == STAT_FULL) |-> resp.comparisons == CMP_W'(TABLE_SIZE))
        else $error("full status with wrong count");

endmodule

// File: sim/dht_checker.sv
`timescale 1ns / 1ps

module dht_checker #(
    parameter int TABLE_SIZE = 37
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  dht_pkg::dht_req_t  req,
    input  logic               done,
    input  dht_pkg::dht_resp_t resp,
    output int                 fail_count,
    output int                 pending,
    output int                 n_requests,
    output int                 n_inserted,
    output int                 n_duplicate,
    output int                 n_full,
    output int                 n_deleted,
    output int                 n_not_found
);

    import dht_pkg::*;

    typedef struct packed {
        dht_req_t  rq;
        dht_resp_t rs;
    } hash_op_t;

    logic [1:0]           slot_mark [TABLE_SIZE];
    logic [KEY_WIDTH-1:0] slot_key  [TABLE_SIZE];

    hash_op_t  expected_ops_q [$];
    hash_op_t  oldest_op;
    dht_resp_t predicted_resp;
    int        n_fail;
    int        n_req;
    int        n_stat [5];

    task automatic flag_error(input string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // double hashing over the slot marks; deleted slots are tombstones
    task automatic predict_hash_op(input dht_req_t r, output dht_resp_t rs);
        longint unsigned kk;
        longint unsigned stride;
        int              slot;
        int              hole;
        int              n;
        int              c;
        bit              hole_ok;
        bit              finished;
        kk       = 64'(r.key);
        stride   = (kk % STEP_PRIME) + 1;
        n        = 0;
        hole     = 0;
        hole_ok  = 1'b0;
        finished = 1'b0;
        rs.status = STAT_NOT_FOUND;
        for (c = 0; c < TABLE_SIZE && !finished; c++)
        begin
            slot = int'((kk + longint'(c) * stride) % TABLE_SIZE);
            if (slot_mark[slot] == MARK_USED)
            begin
                n++;
                if (slot_key[slot] == r.key)
                begin
                    finished = 1'b1;
                    if (r.mode == MODE_INSERT)
                        rs.status = STAT_DUPLICATE;
                    else
                    begin
                        slot_mark[slot] = MARK_DELETED;
                        rs.status       = STAT_DELETED;
                    end
                end
            end
            else if (slot_mark[slot] == MARK_EMPTY)
            begin
                finished = 1'b1;
                if (r.mode == MODE_INSERT)
                begin
                    if (hole_ok)
                        slot = hole;
                    slot_mark[slot] = MARK_USED;
                    slot_key[slot]  = r.key;
                    rs.status       = STAT_INSERTED;
                end
            end
            else if (!hole_ok)
            begin
                hole_ok = 1'b1;
                hole    = slot;
            end
        end
        if (!finished && r.mode == MODE_INSERT)
        begin
            if (hole_ok)
            begin
                slot_mark[hole] = MARK_USED;
                slot_key[hole]  = r.key;
                rs.status       = STAT_INSERTED;
            end
            else
            begin
                rs.status = STAT_FULL;
                n         = TABLE_SIZE;
            end
        end
        rs.comparisons = n[CMP_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                slot_mark[i] = MARK_EMPTY;
                slot_key[i]  = '0;
            end
            expected_ops_q.delete();
            n_fail = 0;
            n_req  = 0;
            for (int i = 0; i < 5; i++)
                n_stat[i] = 0;
        end
        else
        begin
            // result first: one finishing at this edge belongs to an older request
            if (done)
            begin
                if (expected_ops_q.size() == 0)
                    flag_error($sformatf("unexpected result status %0d comparisons %0d",
                                         resp.status, resp.comparisons));
                else
                begin
                    oldest_op = expected_ops_q.pop_front();
                    if (resp.status !== oldest_op.rs.status ||
                        resp.comparisons !== oldest_op.rs.comparisons)
                        flag_error($sformatf(
                            "%s key %0d: expected status %0d comparisons %0d, got %0d %0d",
                            oldest_op.rq.mode == MODE_INSERT ? "insert" : "delete",
                            oldest_op.rq.key, oldest_op.rs.status,
                            oldest_op.rs.comparisons, resp.status, resp.comparisons));
                end
            end
            if (start && !busy)
            begin
                predict_hash_op(req, predicted_resp);
                expected_ops_q.push_back('{rq: req, rs: predicted_resp});
                n_req++;
                if (predicted_resp.status <= STAT_NOT_FOUND)
                    n_stat[predicted_resp.status]++;
            end
        end
        fail_count  <= n_fail;
        pending     <= expected_ops_q.size();
        n_requests  <= n_req;
        n_inserted  <= n_stat[STAT_INSERTED];
        n_duplicate <= n_stat[STAT_DUPLICATE];
        n_full      <= n_stat[STAT_FULL];
        n_deleted   <= n_stat[STAT_DELETED];
        n_not_found <= n_stat[STAT_NOT_FOUND];
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import dht_pkg::*;

    localparam int TABLE_SIZE     = 37;
    localparam int N_ITEMS        = 1100;
    localparam int POOL           = 48;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 100;
    localparam logic [KEY_WIDTH-1:0] KEY_MAX = {KEY_WIDTH{1'b1}};

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    dht_req_t  req;
    logic      done;
    dht_resp_t resp;

    int fail_count;
    int pending;
    int n_requests;
    int n_inserted;
    int n_duplicate;
    int n_full;
    int n_deleted;
    int n_not_found;

    int                   n_sent;
    int                   idle_cycles;
    logic [KEY_WIDTH-1:0] key_pool [POOL];
    logic [KEY_WIDTH-1:0] pool_base;

    double_hash_table_insert_delete_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .resp  (resp)
    );

    dht_checker #(
        .TABLE_SIZE (TABLE_SIZE)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .resp        (resp),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_requests  (n_requests),
        .n_inserted  (n_inserted),
        .n_duplicate (n_duplicate),
        .n_full      (n_full),
        .n_deleted   (n_deleted),
        .n_not_found (n_not_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // mix of wide random keys, keys sharing a home slot, and small keys
    task automatic fill_key(input int idx);
        case ($urandom_range(0, 2))
            0: key_pool[idx] = KEY_WIDTH'($urandom);
            1: key_pool[idx] = KEY_WIDTH'(pool_base + TABLE_SIZE * $urandom_range(0, 15));
            default: key_pool[idx] = KEY_WIDTH'($urandom_range(0, 255));
        endcase
    endtask

    task automatic send_request(input logic m, input logic [KEY_WIDTH-1:0] k, input int gap);
        dht_req_t r;
        r.mode = m;
        r.key  = k;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_sent++;
    endtask

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no request or result for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        int   kind;
        int   phase_len;
        int   insert_pct;
        bit   quiet;
        logic m;
        logic [KEY_WIDTH-1:0] k;
        rst_n  = 1'b0;
        start  = 1'b0;
        req    = '0;
        n_sent = 0;
        pool_base = KEY_WIDTH'($urandom);
        for (int j = 0; j < POOL; j++)
            fill_key(j);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(MODE_INSERT, '0, 0);
        send_request(MODE_INSERT, '0, 0);
        send_request(MODE_INSERT, KEY_MAX, pick_gap());
        send_request(MODE_DELETE, 30'd12345, pick_gap());
        send_request(MODE_DELETE, KEY_MAX, 0);
        send_request(MODE_DELETE, KEY_MAX, pick_gap());
        // 0, 37, 74, 111 share home slot 0
        send_request(MODE_INSERT, 30'd37, 0);
        send_request(MODE_INSERT, 30'd74, pick_gap());
        send_request(MODE_DELETE, 30'd37, 0);
        send_request(MODE_INSERT, 30'd74, 0);
        send_request(MODE_INSERT, 30'd111, pick_gap());
        send_request(MODE_DELETE, '0, 0);
        send_request(MODE_DELETE, 30'd111, 0);
        send_request(MODE_INSERT, 30'd111, pick_gap());
        send_request(MODE_DELETE, 30'd37, 0);
        send_request(MODE_INSERT, 30'h2AAAAAAA, 0);
        send_request(MODE_INSERT, 30'h15555555, pick_gap());
        send_request(MODE_DELETE, 30'h2AAAAAAA, 0);
        send_request(MODE_DELETE, 30'h15555555, pick_gap());
        send_request(MODE_DELETE, 30'd74, 0);
        send_request(MODE_DELETE, 30'd111, 0);

        // phases: fill, mixed, drain over a slowly changing key pool, plus noise
        while (n_sent < N_ITEMS)
        begin
            kind       = $urandom_range(0, 9);
            phase_len  = $urandom_range(30, 120);
            quiet      = ($urandom_range(0, 3) == 0);
            insert_pct = (kind <= 3) ? 85 : (kind <= 6) ? 50 : (kind <= 8) ? 15 : 50;
            if ($urandom_range(0, 2) == 0)
            begin
                pool_base = KEY_WIDTH'($urandom);
                for (int j = 0; j < 12; j++)
                    fill_key($urandom_range(0, POOL - 1));
            end
            for (int i = 0; i < phase_len && n_sent < N_ITEMS; i++)
            begin
                m = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_DELETE;
                if (kind == 9 || $urandom_range(0, 9) == 0)
                    k = KEY_WIDTH'($urandom);
                else
                    k = key_pool[$urandom_range(0, POOL - 1)];
                send_request(m, k, quiet ? 0 : pick_gap());
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d inserted, %0d duplicate, %0d table full,",
                 n_requests, n_inserted, n_duplicate, n_full);
        $display("%0d deleted, %0d not found; %0d mismatching results",
                 n_deleted, n_not_found, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
